/* src/lru_assoc_tag_store_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the LRU tag store
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef LRU_ASSOC_TAG_STORE_TOP_MACROS_SVH
`define LRU_ASSOC_TAG_STORE_TOP_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define LATS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lats: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent
`define LATS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lats: next-cycle check failed");

`endif

/* src/lats_pkg.sv */
// ----------------------------------------------------------------------------
// LRU tag store package
// Sizes, shared types and outcome codes of the fully associative tag store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lats_pkg;

  // Geometry
  localparam int ENTRIES     = 4;
  localparam int BLOCK_BYTES = 16;
  localparam int ADDR_WIDTH  = 32;
  localparam int COUNT_W     = 32;

  // Derived widths
  localparam int ADDR_IN_W = 32;
  localparam int OFFSET_W  = $clog2(BLOCK_BYTES);
  localparam int TAG_W     = ADDR_WIDTH - OFFSET_W;
  localparam int WAY_W     = $clog2(ENTRIES);
  localparam int RANK_W    = $clog2(ENTRIES);

  typedef logic [TAG_W-1:0]   tag_t;
  typedef logic [WAY_W-1:0]   way_t;
  typedef logic [RANK_W-1:0]  rank_t;
  typedef logic [COUNT_W-1:0] count_t;

  // Result codes of one access
  typedef enum logic [1:0] {
    OUTC_HIT        = 2'd0,
    OUTC_COMPULSORY = 2'd1,
    OUTC_CAPACITY   = 2'd2
  } outcome_e;

  // Lookup decision for one access
  typedef struct packed {
    logic     hit;
    logic     fill;
    way_t     way;
    outcome_e outcome;
  } lookup_t;

  // Counter increment requests
  typedef struct packed {
    logic hit;
    logic compulsory;
    logic capacity;
  } cnt_inc_t;

endpackage

/* src/lats_if.sv */
// ----------------------------------------------------------------------------
// LRU tag store channels
// Access request channel and result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lats_in_if;
  import lats_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ADDR_IN_W-1:0] address;
  logic                 final_access;

  modport source (output valid, output address, output final_access, input ready);
  modport sink   (input valid, input address, input final_access, output ready);
endinterface

interface lats_out_if;
  import lats_pkg::*;

  logic     valid;
  logic     ready;
  outcome_e outcome;
  way_t     way;
  count_t   hit_total;
  count_t   compulsory_total;
  count_t   capacity_total;
  logic     final_result;

  modport source (output valid, output outcome, output way, output hit_total,
                  output compulsory_total, output capacity_total, output final_result,
                  input ready);
  modport sink   (input valid, input outcome, input way, input hit_total,
                  input compulsory_total, input capacity_total, input final_result,
                  output ready);
endinterface

/* src/lats_lookup.sv */
// ----------------------------------------------------------------------------
// LRU tag store lookup
// Parallel tag compare, way choice and next recency ranks for one access.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lats_lookup (
  input  lats_pkg::tag_t  tag_i,
  input  logic            valid_i  [lats_pkg::ENTRIES],
  input  lats_pkg::tag_t  etag_i   [lats_pkg::ENTRIES],
  input  lats_pkg::rank_t rank_i   [lats_pkg::ENTRIES],
  output lats_pkg::lookup_t res_o,
  output logic            valid_d_o [lats_pkg::ENTRIES],
  output lats_pkg::rank_t rank_d_o  [lats_pkg::ENTRIES]
);
  import lats_pkg::*;

  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] old_vec;
  way_t               hit_idx;
  way_t               free_idx;
  way_t               old_idx;
  way_t               sel_way;
  logic               any_hit;
  logic               any_free;

  // Compare tags and flag free and oldest entries
  always_comb begin
    for (int j = 0; j < ENTRIES; j++) begin
      hit_vec[j]  = valid_i[j] && (etag_i[j] == tag_i);
      free_vec[j] = !valid_i[j];
      old_vec[j]  = rank_i[j] == rank_t'(ENTRIES - 1);
    end
  end

  // Pick the lowest-numbered entry of each kind
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    old_idx  = '0;
    for (int j = ENTRIES - 1; j >= 0; j--) begin
      if (hit_vec[j])  hit_idx  = way_t'(j);
      if (free_vec[j]) free_idx = way_t'(j);
      if (old_vec[j])  old_idx  = way_t'(j);
    end
  end

  assign any_hit  = |hit_vec;
  assign any_free = |free_vec;

  // Decide outcome and way
  always_comb begin
    res_o.hit  = any_hit;
    res_o.fill = !any_hit && any_free;
    if (any_hit) begin
      sel_way       = hit_idx;
      res_o.outcome = OUTC_HIT;
    end else if (any_free) begin
      sel_way       = free_idx;
      res_o.outcome = OUTC_COMPULSORY;
    end else begin
      sel_way       = old_idx;
      res_o.outcome = OUTC_CAPACITY;
    end
    res_o.way = sel_way;
  end

  // Age entries newer than the touched one (every valid one on a fill), make the touched one most recent
  always_comb begin
    for (int j = 0; j < ENTRIES; j++) begin
      if (way_t'(j) == sel_way) begin
        rank_d_o[j]  = '0;
        valid_d_o[j] = 1'b1;
      end else begin
        valid_d_o[j] = valid_i[j];
        if (valid_i[j] && (res_o.fill || (rank_i[j] < rank_i[sel_way]))) begin
          rank_d_o[j] = rank_i[j] + rank_t'(1);
        end else begin
          rank_d_o[j] = rank_i[j];
        end
      end
    end
  end

endmodule

/* src/lats_counters.sv */
// ----------------------------------------------------------------------------
// LRU tag store counters
// Saturating totals of hits, compulsory misses and capacity misses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lats_counters (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lats_pkg::cnt_inc_t inc_i,
  output lats_pkg::count_t   hit_o,
  output lats_pkg::count_t   compulsory_o,
  output lats_pkg::count_t   capacity_o
);
  import lats_pkg::*;

  count_t hit_q, hit_d;
  count_t comp_q, comp_d;
  count_t cap_q, cap_d;

  // Advance each requested counter, hold at all ones
  always_comb begin
    hit_d  = hit_q;
    comp_d = comp_q;
    cap_d  = cap_q;
    if (inc_i.hit && (hit_q != '1))         hit_d  = hit_q + count_t'(1);
    if (inc_i.compulsory && (comp_q != '1)) comp_d = comp_q + count_t'(1);
    if (inc_i.capacity && (cap_q != '1))    cap_d  = cap_q + count_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= '0;
      comp_q <= '0;
      cap_q  <= '0;
    end else begin
      hit_q  <= hit_d;
      comp_q <= comp_d;
      cap_q  <= cap_d;
    end
  end

  assign hit_o        = hit_q;
  assign compulsory_o = comp_q;
  assign capacity_o   = cap_q;

endmodule

/* src/lru_assoc_tag_store_top.sv */
// An accepted transaction is held in the input register, and its result in the
//   result register; the tag compare and rank update sit between them.
// Throughput: one transaction per cycle unless the result channel stalls.
// Reset clears entry valid bits, recency ranks, totals and both stage valids;
//   stored tags are not cleared and are read only behind their valid bits.
// ----------------------------------------------------------------------------
// LRU tag store top level
// Fully associative tag store with least-recently-used replacement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_assoc_tag_store_top_macros.svh"

module lru_assoc_tag_store_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  lats_in_if.sink    in_i,
  lats_out_if.source out_o
);
  import lats_pkg::*;

  // Input stage
  logic                 in_valid_q;
  logic [ADDR_IN_W-1:0] in_addr_q;
  logic                 in_final_q;

  // Result stage
  logic     out_valid_q;
  outcome_e out_outcome_q;
  way_t     out_way_q;
  logic     out_final_q;

  // Entry state
  logic  valid_q [ENTRIES];
  rank_t rank_q  [ENTRIES];
  tag_t  tag_q   [ENTRIES];
  logic  valid_d [ENTRIES];
  rank_t rank_d  [ENTRIES];

  lookup_t  look;
  cnt_inc_t inc;
  tag_t     acc_tag;
  logic     proc_fire;
  logic     in_fire;
  logic     all_valid;
  logic [ENTRIES-1:0] valid_vec;
  logic [ENTRIES-1:0] oldest_vec;

  // Handshake control
  assign proc_fire = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || proc_fire;
  assign in_fire    = in_i.valid && in_i.ready;

  // Drop the block offset
  assign acc_tag = in_addr_q[ADDR_WIDTH-1:OFFSET_W];

  lats_lookup u_lookup (
    .tag_i     (acc_tag),
    .valid_i   (valid_q),
    .etag_i    (tag_q),
    .rank_i    (rank_q),
    .res_o     (look),
    .valid_d_o (valid_d),
    .rank_d_o  (rank_d)
  );

  // Request the counter for this outcome
  always_comb begin
    inc.hit        = proc_fire && (look.outcome == OUTC_HIT);
    inc.compulsory = proc_fire && (look.outcome == OUTC_COMPULSORY);
    inc.capacity   = proc_fire && (look.outcome == OUTC_CAPACITY);
  end

  lats_counters u_counters (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .inc_i        (inc),
    .hit_o        (out_o.hit_total),
    .compulsory_o (out_o.compulsory_total),
    .capacity_o   (out_o.capacity_total)
  );

  // Control state: stage valids, entry valids and ranks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < ENTRIES; j++) begin
        valid_q[j] <= 1'b0;
        rank_q[j]  <= '0;
      end
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (proc_fire) begin
        out_valid_q <= 1'b1;
        for (int j = 0; j < ENTRIES; j++) begin
          valid_q[j] <= valid_d[j];
          rank_q[j]  <= rank_d[j];
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers and tag store
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_addr_q  <= in_i.address;
      in_final_q <= in_i.final_access;
    end
    if (proc_fire) begin
      out_outcome_q <= look.outcome;
      out_way_q     <= look.way;
      out_final_q   <= in_final_q;
      if (!look.hit) begin
        tag_q[look.way] <= acc_tag;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.outcome      = out_outcome_q;
  assign out_o.way          = out_way_q;
  assign out_o.final_result = out_final_q;

  // Flatten state for checks
  always_comb begin
    for (int j = 0; j < ENTRIES; j++) begin
      valid_vec[j]  = valid_q[j];
      oldest_vec[j] = valid_q[j] && (rank_q[j] == rank_t'(ENTRIES - 1));
    end
  end
  assign all_valid = &valid_vec;

  `LATS_ASSERT_SAME(a_full_one_oldest, all_valid, $onehot(oldest_vec))
  `LATS_ASSERT_NEXT(a_valid_only_grows, 1'b1, (valid_vec & $past(valid_vec)) == $past(valid_vec))
  `LATS_ASSERT_SAME(a_capacity_only_full, proc_fire && (look.outcome == OUTC_CAPACITY), all_valid)
  `LATS_ASSERT_SAME(a_result_rises_on_fire, $rose(out_valid_q), $past(proc_fire))

endmodule
